// ===== rtl/core/gvs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gvs_pkg
// Shared types and constants of the gated velocity smoother.
// ----------------------------------------------------------------------------
package gvs_pkg;

	// register and field widths
	localparam int CONF_W     = 16;
	localparam int SPD_W      = 23;
	localparam int GAIN_W     = 16;
	localparam int ALPHA_W    = 17;
	localparam int STAT_W     = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	// shared multiplier: MW x MW operands, one 8-bit digit of b per cycle
	localparam int MW        = 39;
	localparam int PW        = 2 * MW;
	localparam int GS_W      = GAIN_W + SPD_W;
	localparam int DIG_W     = 8;
	localparam int MUL_STEPS = (MW + DIG_W - 1) / DIG_W;

	// root and divide units, one bit per cycle
	localparam int ROOT_W = 24;
	localparam int SQ_N_W = 2 * ROOT_W;
	localparam int QB     = 24;
	localparam int CNT_W  = 5;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

	typedef enum logic [STAT_W-1:0] {
		ST_SMOOTH     = 3'd0,
		ST_LOW_CONF   = 3'd1,
		ST_NON_FINITE = 3'd2,
		ST_SPIKE      = 3'd3,
		ST_CLEARED    = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_CONF  = 3'd0,
		REG_MAX_SPEED = 3'd1,
		REG_GAIN      = 3'd2,
		REG_ALPHA     = 3'd3,
		REG_FALLBACK  = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		U_NONE,
		U_MUL,
		U_SQRT,
		U_DIV
	} unit_t;

	typedef enum logic [3:0] {
		M_DXDX,
		M_DYDY,
		M_GAINSPR,
		M_GSGS,
		M_FBFB,
		M_AXAX,
		M_AYAY,
		M_MSMS,
		M_AXMS,
		M_AYMS,
		M_EMAX,
		M_EMAY
	} mul_sel_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECIDE,
		S_DXDX,
		S_DYDY,
		S_GAINSPR,
		S_GSGS,
		S_FBFB,
		S_SPIKE,
		S_CLAMP,
		S_AXAX,
		S_AYAY,
		S_MSMS,
		S_RADIAL,
		S_SQRT,
		S_AXMS,
		S_DIVX,
		S_AYMS,
		S_DIVY,
		S_COMMIT,
		S_EMAX,
		S_EMAY,
		S_FIN
	} state_t;

	typedef struct packed {
		logic     load;
		logic     clear;
		logic     clamp;
		logic     commit;
		logic     publish;
		logic     start;
		unit_t    unit;
		mul_sel_t sel;
		status_t  status;
	} dp_cmd_t;

	typedef struct packed {
		logic is_clear;
		logic low_conf;
		logic non_finite;
		logic primed;
		logic spread_big;
		logic spike;
		logic over;
		logic done;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/gvs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gvs_ctrl
// Sequencer: walks one item through gating, clamping, scaling and smoothing.
// ----------------------------------------------------------------------------
module gvs_ctrl import gvs_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  wire logic     out_stall,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	state_t  state_q, state_d;
	status_t st_q, st_d;
	logic    go_q;
	logic    out_valid_q;
	logic    slot_free;

	assign slot_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				priority if (stat.is_clear) begin
					st_d    = ST_CLEARED;
					state_d = S_FIN;
				end else if (stat.low_conf) begin
					st_d    = ST_LOW_CONF;
					state_d = S_FIN;
				end else if (stat.non_finite) begin
					st_d    = ST_NON_FINITE;
					state_d = S_FIN;
				end else if (stat.primed) begin
					state_d = S_DXDX;
				end else begin
					state_d = S_CLAMP;
				end
			end
			S_DXDX:    if (stat.done) state_d = S_DYDY;
			S_DYDY:    if (stat.done) state_d = stat.spread_big ? S_GAINSPR : S_FBFB;
			S_GAINSPR: if (stat.done) state_d = S_GSGS;
			S_GSGS:    if (stat.done) state_d = S_SPIKE;
			S_FBFB:    if (stat.done) state_d = S_SPIKE;
			S_SPIKE: begin
				if (stat.spike) begin
					st_d    = ST_SPIKE;
					state_d = S_FIN;
				end else begin
					state_d = S_CLAMP;
				end
			end
			S_CLAMP:   state_d = S_AXAX;
			S_AXAX:    if (stat.done) state_d = S_AYAY;
			S_AYAY:    if (stat.done) state_d = S_MSMS;
			S_MSMS:    if (stat.done) state_d = S_RADIAL;
			S_RADIAL:  state_d = stat.over ? S_SQRT : S_COMMIT;
			S_SQRT:    if (stat.done) state_d = S_AXMS;
			S_AXMS:    if (stat.done) state_d = S_DIVX;
			S_DIVX:    if (stat.done) state_d = S_AYMS;
			S_AYMS:    if (stat.done) state_d = S_DIVY;
			S_DIVY:    if (stat.done) state_d = S_COMMIT;
			S_COMMIT: begin
				st_d    = ST_SMOOTH;
				state_d = stat.primed ? S_EMAX : S_FIN;
			end
			S_EMAX:    if (stat.done) state_d = S_EMAY;
			S_EMAY:    if (stat.done) state_d = S_FIN;
			S_FIN:     if (slot_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd         = '0;
		cmd.unit    = U_NONE;
		cmd.sel     = M_DXDX;
		cmd.status  = st_q;
		cmd.load    = (state_q == S_IDLE) && in_valid;
		cmd.clear   = (state_q == S_DECIDE) && stat.is_clear;
		cmd.clamp   = (state_q == S_CLAMP);
		cmd.commit  = (state_q == S_COMMIT) && !stat.primed;
		cmd.publish = (state_q == S_FIN) && slot_free;
		unique case (state_q)
			S_DXDX:    begin cmd.unit = U_MUL;  cmd.sel = M_DXDX;    end
			S_DYDY:    begin cmd.unit = U_MUL;  cmd.sel = M_DYDY;    end
			S_GAINSPR: begin cmd.unit = U_MUL;  cmd.sel = M_GAINSPR; end
			S_GSGS:    begin cmd.unit = U_MUL;  cmd.sel = M_GSGS;    end
			S_FBFB:    begin cmd.unit = U_MUL;  cmd.sel = M_FBFB;    end
			S_AXAX:    begin cmd.unit = U_MUL;  cmd.sel = M_AXAX;    end
			S_AYAY:    begin cmd.unit = U_MUL;  cmd.sel = M_AYAY;    end
			S_MSMS:    begin cmd.unit = U_MUL;  cmd.sel = M_MSMS;    end
			S_AXMS:    begin cmd.unit = U_MUL;  cmd.sel = M_AXMS;    end
			S_AYMS:    begin cmd.unit = U_MUL;  cmd.sel = M_AYMS;    end
			S_EMAX:    begin cmd.unit = U_MUL;  cmd.sel = M_EMAX;    end
			S_EMAY:    begin cmd.unit = U_MUL;  cmd.sel = M_EMAY;    end
			S_SQRT:    begin cmd.unit = U_SQRT;                      end
			S_DIVX:    begin cmd.unit = U_DIV;  cmd.sel = M_AXMS;    end
			S_DIVY:    begin cmd.unit = U_DIV;  cmd.sel = M_AYMS;    end
			default:   begin cmd.unit = U_NONE;                      end
		endcase
		cmd.start = (cmd.unit != U_NONE) && !go_q;
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			st_q        <= ST_SMOOTH;
			go_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			go_q    <= (cmd.unit != U_NONE) && !stat.done;
			if (cmd.publish) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/gvs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gvs_datapath
// Item latches, smoothing state, shared digit-serial multiplier, bit-serial
// square root and divider, and the result register.
// ----------------------------------------------------------------------------
module gvs_datapath import gvs_pkg::*; #(
	parameter int VEL_WIDTH = 24,
	parameter int FRAC_BITS = 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire dp_cmd_t                     cmd,
	output dp_stat_t                         stat,
	input  wire logic                        in_cmd,
	input  wire logic signed [VEL_WIDTH-1:0] in_vx,
	input  wire logic signed [VEL_WIDTH-1:0] in_vy,
	input  wire logic signed [VEL_WIDTH-1:0] in_px,
	input  wire logic signed [VEL_WIDTH-1:0] in_py,
	input  wire logic [CONF_W-1:0]           in_conf,
	input  wire logic [SPD_W-1:0]            in_spread,
	input  wire logic                        in_nonfin,
	input  wire logic [CONF_W-1:0]           min_conf,
	input  wire logic [SPD_W-1:0]            max_speed,
	input  wire logic [GAIN_W-1:0]           gain,
	input  wire logic [ALPHA_W-1:0]          alpha,
	input  wire logic [SPD_W-1:0]            fallback,
	output logic signed [VEL_WIDTH-1:0]      res_x,
	output logic signed [VEL_WIDTH-1:0]      res_y,
	output logic [STAT_W-1:0]                res_status
);

	localparam int W  = VEL_WIDTH;
	localparam int XW = ((W > QB) ? W : QB) + 2;
	localparam int TW = W + 19;
	localparam logic [SPD_W-1:0] ONE_SPR = SPD_W'(1) << FRAC_BITS;

	// item latches
	logic                cmd_q, nonfin_q;
	logic signed [W-1:0] vx_q, vy_q, px_q, py_q;
	logic [CONF_W-1:0]   conf_q;
	logic [SPD_W-1:0]    spr_q;

	// filter state
	logic signed [W-1:0] sx_q, sy_q;
	logic                primed_q;

	// working values
	logic signed [W-1:0] cx_q, cy_q;
	logic [PW-1:0]       d2_q, s2_q, thr_q, num_q;
	logic [GS_W-1:0]     gs_q;
	logic [ROOT_W-1:0]   mag_q;

	// unit control
	unit_t               unit_q;
	mul_sel_t            sel_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                done;

	// multiplier
	logic [PW-1:0]       a_sh_q, acc_q, mpart, mul_next;
	logic [MW-1:0]       b_q;
	logic [MW-1:0]       op_a, op_b;

	// root
	logic [ROOT_W+1:0]   sq_rem_q;
	logic [ROOT_W-1:0]   sq_root_q, sq_root_n;
	logic [SQ_N_W-1:0]   sq_n_q;
	logic [ROOT_W+3:0]   sq_rem2, sq_trial, sq_rem_n;
	logic                sq_ge;

	// divider
	logic [QB:0]         dv_rem_q, dv_r2, dv_rem_n;
	logic [QB-1:0]       dv_n_q, dv_q_q, dv_q_n;
	logic [PW-1:0]       num_sh;
	logic                dv_ge;
	logic                dv_neg;
	logic signed [XW-1:0] dv_qe, dv_res;

	// differences and magnitudes
	logic signed [W:0]   dvx, dvy, dex, dey;
	logic [W:0]          dx, dy, adex, adey;
	logic [W-1:0]        ax, ay;
	logic [ALPHA_W-1:0]  alpha_sat;

	// clamp
	logic signed [XW-1:0] ms_e, vxe, vye, clx, cly;

	// EMA
	logic                ema_neg;
	logic signed [TW-1:0] ema_t, ema_sh;
	logic signed [W-1:0] ema_new;

	// spike and radial tests
	logic [PW+15:0]      d2_sh, thr_e;

	// differences to the prior sample and to the held state
	assign dvx  = $signed({vx_q[W-1], vx_q}) - $signed({px_q[W-1], px_q});
	assign dvy  = $signed({vy_q[W-1], vy_q}) - $signed({py_q[W-1], py_q});
	assign dx   = dvx[W] ? (W+1)'(-dvx) : (W+1)'(dvx);
	assign dy   = dvy[W] ? (W+1)'(-dvy) : (W+1)'(dvy);
	assign dex  = $signed({cx_q[W-1], cx_q}) - $signed({sx_q[W-1], sx_q});
	assign dey  = $signed({cy_q[W-1], cy_q}) - $signed({sy_q[W-1], sy_q});
	assign adex = dex[W] ? (W+1)'(-dex) : (W+1)'(dex);
	assign adey = dey[W] ? (W+1)'(-dey) : (W+1)'(dey);
	assign ax   = cx_q[W-1] ? W'(-cx_q) : W'(cx_q);
	assign ay   = cy_q[W-1] ? W'(-cy_q) : W'(cy_q);
	assign alpha_sat = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;

	// per-axis clamp to +-max_speed
	assign ms_e = XW'($signed({1'b0, max_speed}));
	assign vxe  = XW'(vx_q);
	assign vye  = XW'(vy_q);
	always_comb begin
		priority if (vxe > ms_e) clx = ms_e;
		else if (vxe < -ms_e)    clx = -ms_e;
		else                     clx = vxe;
		priority if (vye > ms_e) cly = ms_e;
		else if (vye < -ms_e)    cly = -ms_e;
		else                     cly = vye;
	end

	// multiplier operand select
	always_comb begin
		unique case (cmd.sel)
			M_DXDX:    begin op_a = MW'(dx);        op_b = MW'(dx);        end
			M_DYDY:    begin op_a = MW'(dy);        op_b = MW'(dy);        end
			M_GAINSPR: begin op_a = MW'(gain);      op_b = MW'(spr_q);     end
			M_GSGS:    begin op_a = MW'(gs_q);      op_b = MW'(gs_q);      end
			M_FBFB:    begin op_a = MW'(fallback);  op_b = MW'(fallback);  end
			M_AXAX:    begin op_a = MW'(ax);        op_b = MW'(ax);        end
			M_AYAY:    begin op_a = MW'(ay);        op_b = MW'(ay);        end
			M_MSMS:    begin op_a = MW'(max_speed); op_b = MW'(max_speed); end
			M_AXMS:    begin op_a = MW'(ax);        op_b = MW'(max_speed); end
			M_AYMS:    begin op_a = MW'(ay);        op_b = MW'(max_speed); end
			M_EMAX:    begin op_a = MW'(adex);      op_b = MW'(alpha_sat); end
			M_EMAY:    begin op_a = MW'(adey);      op_b = MW'(alpha_sat); end
			default:   begin op_a = '0;             op_b = '0;             end
		endcase
	end

	// one 8-bit digit of b per cycle
	assign mpart    = a_sh_q * PW'(b_q[DIG_W-1:0]);
	assign mul_next = acc_q + mpart;

	// one root bit per cycle
	assign sq_rem2   = {sq_rem_q, sq_n_q[SQ_N_W-1 -: 2]};
	assign sq_trial  = {2'b00, sq_root_q, 2'b01};
	assign sq_ge     = (sq_rem2 >= sq_trial);
	assign sq_rem_n  = sq_ge ? (sq_rem2 - sq_trial) : sq_rem2;
	assign sq_root_n = {sq_root_q[ROOT_W-2:0], sq_ge};

	// one quotient bit per cycle
	assign num_sh   = num_q >> QB;
	assign dv_r2    = {dv_rem_q[QB-1:0], dv_n_q[QB-1]};
	assign dv_ge    = (dv_r2 >= {1'b0, mag_q});
	assign dv_rem_n = dv_ge ? (dv_r2 - {1'b0, mag_q}) : dv_r2;
	assign dv_q_n   = {dv_q_q[QB-2:0], dv_ge};
	assign dv_neg   = (sel_q == M_AXMS) ? cx_q[W-1] : cy_q[W-1];
	assign dv_qe    = XW'($signed({1'b0, dv_q_n}));
	assign dv_res   = dv_neg ? -dv_qe : dv_qe;

	// EMA: s + floor((a*(c - s) + 32768) / 65536), alpha in Q1.16
	assign ema_neg = (sel_q == M_EMAX) ? dex[W] : dey[W];
	assign ema_t   = ema_neg ? -$signed(mul_next[TW-1:0]) : $signed(mul_next[TW-1:0]);
	assign ema_sh  = (ema_t + TW'(32768)) >>> 16;
	assign ema_new = ((sel_q == M_EMAX) ? sx_q : sy_q) + ema_sh[W-1:0];

	// threshold compares
	assign d2_sh = {d2_q, 16'b0};
	assign thr_e = {16'b0, thr_q};

	assign done = (cnt_q == CNT_W'(1));

	always_comb begin
		stat.is_clear   = cmd_q;
		stat.low_conf   = (conf_q < min_conf);
		stat.non_finite = nonfin_q;
		stat.primed     = primed_q;
		stat.spread_big = (spr_q > ONE_SPR);
		stat.spike      = stat.spread_big ? (d2_sh > thr_e) : (d2_q > thr_q);
		stat.over       = (s2_q > thr_q);
		stat.done       = done;
	end

	// unit sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			unit_q <= U_NONE;
			sel_q  <= M_DXDX;
		end else if (cmd.start) begin
			unit_q <= cmd.unit;
			sel_q  <= cmd.sel;
			unique case (cmd.unit)
				U_MUL:   cnt_q <= CNT_W'(MUL_STEPS);
				U_SQRT:  cnt_q <= CNT_W'(ROOT_W);
				U_DIV:   cnt_q <= CNT_W'(QB);
				default: cnt_q <= '0;
			endcase
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// iterative units
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			a_sh_q    <= PW'(op_a);
			b_q       <= op_b;
			acc_q     <= '0;
			sq_rem_q  <= '0;
			sq_root_q <= '0;
			sq_n_q    <= s2_q[SQ_N_W-1:0];
			dv_rem_q  <= num_sh[QB:0];
			dv_n_q    <= num_q[QB-1:0];
			dv_q_q    <= '0;
		end else if (cnt_q != '0) begin
			a_sh_q    <= a_sh_q << DIG_W;
			b_q       <= b_q >> DIG_W;
			acc_q     <= mul_next;
			sq_rem_q  <= sq_rem_n[ROOT_W+1:0];
			sq_root_q <= sq_root_n;
			sq_n_q    <= sq_n_q << 2;
			dv_rem_q  <= dv_rem_n;
			dv_n_q    <= dv_n_q << 1;
			dv_q_q    <= dv_q_n;
		end
	end

	// item latches and working values
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q    <= in_cmd;
			vx_q     <= in_vx;
			vy_q     <= in_vy;
			px_q     <= in_px;
			py_q     <= in_py;
			conf_q   <= in_conf;
			spr_q    <= in_spread;
			nonfin_q <= in_nonfin;
		end
		if (cmd.clamp) begin
			cx_q <= clx[W-1:0];
			cy_q <= cly[W-1:0];
		end
		if (done) begin
			unique case (unit_q)
				U_MUL: begin
					unique case (sel_q)
						M_DXDX:    d2_q  <= mul_next;
						M_DYDY:    d2_q  <= d2_q + mul_next;
						M_GAINSPR: gs_q  <= mul_next[GS_W-1:0];
						M_GSGS:    thr_q <= mul_next;
						M_FBFB:    thr_q <= mul_next;
						M_AXAX:    s2_q  <= mul_next;
						M_AYAY:    s2_q  <= s2_q + mul_next;
						M_MSMS:    thr_q <= mul_next;
						M_AXMS:    num_q <= mul_next;
						M_AYMS:    num_q <= mul_next;
						default:   ;
					endcase
				end
				U_SQRT: mag_q <= sq_root_n;
				U_DIV: begin
					if (sel_q == M_AXMS) cx_q <= dv_res[W-1:0];
					else                 cy_q <= dv_res[W-1:0];
				end
				default: ;
			endcase
		end
		if (cmd.publish) begin
			res_x      <= sx_q;
			res_y      <= sy_q;
			res_status <= cmd.status;
		end
	end

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q     <= '0;
			sy_q     <= '0;
			primed_q <= 1'b0;
		end else if (cmd.clear) begin
			sx_q     <= '0;
			sy_q     <= '0;
			primed_q <= 1'b0;
		end else if (cmd.commit) begin
			sx_q     <= cx_q;
			sy_q     <= cy_q;
			primed_q <= 1'b1;
		end else if (done && unit_q == U_MUL && sel_q == M_EMAX) begin
			sx_q <= ema_new;
		end else if (done && unit_q == U_MUL && sel_q == M_EMAY) begin
			sy_q <= ema_new;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/gated_velocity_smoother.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gated_velocity_smoother
// Outlier-gated exponential smoothing of a 2-D velocity.
// ----------------------------------------------------------------------------
// One item is worked on at a time; in_stall is high from acceptance until the
// result is placed in the output register, which then holds it until taken
// while the next item is accepted. A clear, a low-confidence or a non-finite
// sample goes from the decision state straight to the final state. Products
// run on a shared multiplier that retires 8 bits of its second operand per
// cycle. Once primed, the spike test runs three products (four when the spread
// exceeds one), and a spike then ends the item. The clamp adds three products
// and, once primed, the smoothing step two; when radial scaling is needed, a
// square root, two more products and two divisions are added. A stalled output
// holds the item in the final state until the output register is free.
module gated_velocity_smoother import gvs_pkg::*; #(
	parameter int VEL_WIDTH = 24,
	parameter int FRAC_BITS = 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration
	input  wire logic                        cfg_en,
	input  wire logic [CFG_IDX_W-1:0]        cfg_addr,
	input  wire logic [CFG_DATA_W-1:0]       cfg_data,
	// input item
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        cmd,
	input  wire logic signed [VEL_WIDTH-1:0] vel_x,
	input  wire logic signed [VEL_WIDTH-1:0] vel_y,
	input  wire logic signed [VEL_WIDTH-1:0] prior_x,
	input  wire logic signed [VEL_WIDTH-1:0] prior_y,
	input  wire logic [CONF_W-1:0]           sample_confidence,
	input  wire logic [SPD_W-1:0]            spread,
	input  wire logic                        non_finite,
	// result item
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic signed [VEL_WIDTH-1:0]      out_x,
	output logic signed [VEL_WIDTH-1:0]      out_y,
	output logic [STAT_W-1:0]                status
);

	logic [CONF_W-1:0]  min_conf_q;
	logic [SPD_W-1:0]   max_speed_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [ALPHA_W-1:0] alpha_q;
	logic [SPD_W-1:0]   fallback_q;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_conf_q  <= 16'd32768;
			max_speed_q <= 23'd512000;
			gain_q      <= 16'd768;
			alpha_q     <= 17'd32768;
			fallback_q  <= 23'd12800;
		end else if (cfg_en) begin
			unique case (cfg_addr)
				REG_MIN_CONF:  min_conf_q  <= cfg_data[CONF_W-1:0];
				REG_MAX_SPEED: max_speed_q <= cfg_data[SPD_W-1:0];
				REG_GAIN:      gain_q      <= cfg_data[GAIN_W-1:0];
				REG_ALPHA:     alpha_q     <= cfg_data[ALPHA_W-1:0];
				REG_FALLBACK:  fallback_q  <= cfg_data[SPD_W-1:0];
				default:       ;
			endcase
		end
	end

	gvs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (dp_stat),
		.cmd       (dp_cmd)
	);

	gvs_datapath #(
		.VEL_WIDTH (VEL_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (dp_cmd),
		.stat       (dp_stat),
		.in_cmd     (cmd),
		.in_vx      (vel_x),
		.in_vy      (vel_y),
		.in_px      (prior_x),
		.in_py      (prior_y),
		.in_conf    (sample_confidence),
		.in_spread  (spread),
		.in_nonfin  (non_finite),
		.min_conf   (min_conf_q),
		.max_speed  (max_speed_q),
		.gain       (gain_q),
		.alpha      (alpha_q),
		.fallback   (fallback_q),
		.res_x      (out_x),
		.res_y      (out_y),
		.res_status (status)
	);

endmodule
`default_nettype wire

// ===== rtl/core/gvs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gvs_checker
// Port-level checks of the smoother, bound to the top level.
// ----------------------------------------------------------------------------
module gvs_checker import gvs_pkg::*; #(
	parameter int VEL_WIDTH = 24
) (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_stall,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic signed [VEL_WIDTH-1:0] out_x,
	input wire logic signed [VEL_WIDTH-1:0] out_y,
	input wire logic [STAT_W-1:0]           status
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// one item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item accepted while another is in work");

	// no result appears the cycle after an item is taken
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result appeared too early");

	// a clear returns zero velocity
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_CLEARED |-> out_x == '0 && out_y == '0)
		else $error("clear returned nonzero velocity");

endmodule

bind gated_velocity_smoother gvs_checker #(.VEL_WIDTH(VEL_WIDTH)) u_gvs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_x     (out_x),
	.out_y     (out_y),
	.status    (status)
);
`default_nettype wire

// ===== verif/tb_gated_velocity_smoother.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gated_velocity_smoother
// Drives filter and clear items with random gaps and output stalls, predicts
// the smoothed velocity and status of each item, and compares every result.
// ----------------------------------------------------------------------------
module tb_gated_velocity_smoother;
	import gvs_pkg::*;

	localparam int VW = 24;
	localparam int FB = 8;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct {
		logic          cmd;
		logic [VW-1:0] vx, vy, px, py;
		logic [15:0]   conf;
		logic [22:0]   spr;
		logic          nf;
	} sample_t;

	typedef struct {
		logic [VW-1:0] x, y;
		logic [2:0]    st;
	} filtered_t;

	logic clk = 0, arst_n = 0;
	logic cfg_en = 0;
	logic [CFG_IDX_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 0, in_stall, out_valid, out_stall = 0;
	logic cmd = 0, non_finite = 0;
	logic signed [VW-1:0] vel_x = 0, vel_y = 0, prior_x = 0, prior_y = 0;
	logic [15:0] sample_confidence = 0;
	logic [22:0] spread = 0;
	logic signed [VW-1:0] out_x, out_y;
	logic [STAT_W-1:0] status;

	gated_velocity_smoother #(.VEL_WIDTH(VW), .FRAC_BITS(FB)) i_dut (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// predictor state and settings
	longint unsigned min_conf, max_spd, gain, alpha, fallback;
	longint sm_x, sm_y;
	bit primed;

	sample_t pending[$];
	filtered_t expected_q[$];
	int errors = 0;
	int cycles = 0;
	int hold_off = 0;

	function automatic longint sx(logic [VW-1:0] v);
		return longint'(signed'(v));
	endfunction

	function automatic longint unsigned isqrt(longint unsigned n);
		longint unsigned r = 0, b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint ema(longint c, longint s, longint a);
		longint t;
		t = a * c + (65536 - a) * s + 32768;
		return t >>> 16;
	endfunction

	// compute result of one item and advance the predictor
	function automatic filtered_t smooth_sample(sample_t s);
		filtered_t r;
		longint vx, vy, px, py, cx, cy, a;
		logic [127:0] d2, th;
		longint unsigned dx, dy, gs, ax, ay, mag;
		vx = sx(s.vx); vy = sx(s.vy); px = sx(s.px); py = sx(s.py);
		if (s.cmd) begin
			sm_x = 0; sm_y = 0; primed = 0;
			r.st = ST_CLEARED;
		end else if (s.conf < min_conf) r.st = ST_LOW_CONF;
		else if (s.nf) r.st = ST_NON_FINITE;
		else begin
			dx = (vx > px) ? vx - px : px - vx;
			dy = (vy > py) ? vy - py : py - vy;
			d2 = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
			if (s.spr > (64'd1 << FB)) begin
				gs = gain * s.spr;
				th = 128'(gs) * 128'(gs);
				d2 = d2 << 16;
			end else
				th = 128'(fallback) * 128'(fallback);
			if (primed && d2 > th) r.st = ST_SPIKE;
			else begin
				cx = vx > longint'(max_spd) ? longint'(max_spd) :
					(vx < -longint'(max_spd) ? -longint'(max_spd) : vx);
				cy = vy > longint'(max_spd) ? longint'(max_spd) :
					(vy < -longint'(max_spd) ? -longint'(max_spd) : vy);
				ax = cx < 0 ? -cx : cx;
				ay = cy < 0 ? -cy : cy;
				if (ax * ax + ay * ay > max_spd * max_spd) begin
					mag = isqrt(ax * ax + ay * ay);
					cx = cx < 0 ? -longint'(ax * max_spd / mag) : longint'(ax * max_spd / mag);
					cy = cy < 0 ? -longint'(ay * max_spd / mag) : longint'(ay * max_spd / mag);
				end
				if (!primed) begin
					sm_x = cx; sm_y = cy; primed = 1;
				end else begin
					a = alpha > 65536 ? 65536 : alpha;
					sm_x = ema(cx, sm_x, a);
					sm_y = ema(cy, sm_y, a);
				end
				r.st = ST_SMOOTH;
			end
		end
		r.x = sm_x[VW-1:0];
		r.y = sm_y[VW-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// driver: one item per handshake with a random gap before each
	int gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_q.push_back(smooth_sample(pending.pop_front()));
				gap <= $urandom_range(0, 11) * $urandom_range(0, 1);
				in_valid <= 0;
			end else if (!in_valid && gap > 0)
				gap <= gap - 1;
			else if (!in_valid && pending.size() > 0) begin
				cmd <= pending[0].cmd;
				vel_x <= pending[0].vx; vel_y <= pending[0].vy;
				prior_x <= pending[0].px; prior_y <= pending[0].py;
				sample_confidence <= pending[0].conf;
				spread <= pending[0].spr;
				non_finite <= pending[0].nf;
				in_valid <= 1;
			end
		end
	end

	// long receiver hold-off, counted down in its own process
	always @(posedge clk) begin
		if (hold_off > 0)
			hold_off <= hold_off - 1;
	end

	// monitor: compare each result, draw output stall
	int ostall = 0;
	always @(posedge clk) begin
		filtered_t e;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
		if (out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				e = expected_q.pop_front();
				if (out_x !== e.x) report_mismatch("out_x", sx(out_x), sx(e.x));
				if (out_y !== e.y) report_mismatch("out_y", sx(out_y), sx(e.y));
				if (status !== e.st) report_mismatch("status", status, e.st);
			end
			ostall <= $urandom_range(0, 11) * $urandom_range(0, 1);
		end else if (ostall > 0)
			ostall <= ostall - 1;
		if (hold_off > 0)
			out_stall <= 1;
		else
			out_stall <= (ostall > 1);
	end

	task automatic write_reg(cfg_reg_t idx, longint unsigned v);
		@(posedge clk);
		cfg_en <= 1; cfg_addr <= idx; cfg_data <= v[22:0];
		case (idx)
			REG_MIN_CONF:  min_conf = v & 16'hFFFF;
			REG_MAX_SPEED: max_spd = v & 23'h7FFFFF;
			REG_GAIN:      gain = v & 16'hFFFF;
			REG_ALPHA:     alpha = v & 17'h1FFFF;
			default:       fallback = v & 23'h7FFFFF;
		endcase
		@(posedge clk);
		cfg_en <= 0;
	endtask

	function automatic logic [VW-1:0] rvel(int scale);
		longint v;
		case ($urandom_range(0, 5))
			0: v = $urandom;
			1: v = longint'($urandom_range(0, scale)) - scale / 2;
			default: v = longint'($urandom_range(0, 2 * scale)) - scale;
		endcase
		return v[VW-1:0];
	endfunction

	task automatic add_sample(logic c, logic [VW-1:0] vx, vy, px, py,
			logic [15:0] cf, logic [22:0] sp, logic n);
		sample_t s;
		s.cmd = c; s.vx = vx; s.vy = vy; s.px = px; s.py = py;
		s.conf = cf; s.spr = sp; s.nf = n;
		pending.push_back(s);
	endtask

	task automatic add_random(int n);
		logic [VW-1:0] vx, vy, d;
		for (int i = 0; i < n; i++) begin
			vx = rvel(200000);
			vy = rvel(200000);
			if ($urandom_range(0, 3) == 0) d = rvel(40000);
			else d = rvel(4000);
			add_sample($urandom_range(0, 30) == 0, vx, vy, vx + d, vy - rvel(3000),
				$urandom_range(0, 4) == 0 ? 16'($urandom) : 16'($urandom_range(30000, 65535)),
				$urandom_range(0, 2) == 0 ? 23'($urandom_range(0, 300)) :
					($urandom_range(0, 9) == 0 ? 23'($urandom) : 23'($urandom_range(0, 20000))),
				$urandom_range(0, 15) == 0);
		end
	endtask

	// wait for all results and for the block to settle
	task automatic drain;
		while (pending.size() > 0 || expected_q.size() > 0 || in_valid) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	initial begin
		min_conf = 32768; max_spd = 512000; gain = 768; alpha = 32768; fallback = 12800;
		sm_x = 0; sm_y = 0; primed = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;

		// directed: extremes, each rejection, clear, radial scaling
		add_sample(0, 24'h7FFFFF, 24'h800000, 0, 0, 16'hFFFF, 0, 0);
		add_sample(0, 100, 100, 0, 0, 0, 0, 0);
		add_sample(0, 100, 100, 0, 0, 16'hFFFF, 0, 1);
		add_sample(0, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 16'hFFFF, 23'h7FFFFF, 0);
		add_sample(0, 0, 0, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 256, 0);
		add_sample(0, 1000, 0, 0, 0, 16'hFFFF, 257, 0);
		add_sample(0, 12800, 0, 0, 0, 32768, 256, 0);
		add_sample(0, 12801, 0, 0, 0, 32768, 256, 0);
		add_sample(0, 400000, 400000, 400000, 400000, 32767, 100, 0);
		add_sample(1, 0, 0, 0, 0, 0, 0, 1);
		add_sample(0, 24'h800000, 24'h7FFFFF, 0, 0, 32768, 0, 0);
		add_sample(0, -1, -1, -1, -1, 40000, 5000, 0);
		add_sample(1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 23'h7FFFFF, 1);
		drain();

		// several settings, extremes included; each followed by random items
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_MIN_CONF, 0); write_reg(REG_MAX_SPEED, 23'h7FFFFF);
					write_reg(REG_GAIN, 16'hFFFF); write_reg(REG_ALPHA, 65536);
					write_reg(REG_FALLBACK, 23'h7FFFFF);
				end
				1: begin
					write_reg(REG_MIN_CONF, 16'hFFFF); write_reg(REG_MAX_SPEED, 0);
					write_reg(REG_GAIN, 0); write_reg(REG_ALPHA, 0);
					write_reg(REG_FALLBACK, 0);
				end
				2: begin
					write_reg(REG_MIN_CONF, 20000); write_reg(REG_MAX_SPEED, 100000);
					write_reg(REG_GAIN, 512); write_reg(REG_ALPHA, 17'h1FFFF);
					write_reg(REG_FALLBACK, 5000);
				end
				default: begin
					write_reg(REG_MIN_CONF, $urandom_range(0, 50000));
					write_reg(REG_MAX_SPEED, $urandom_range(1, 300000));
					write_reg(REG_GAIN, $urandom_range(0, 65535));
					write_reg(REG_ALPHA, $urandom_range(0, 65536));
					write_reg(REG_FALLBACK, $urandom_range(0, 50000));
				end
			endcase
			add_sample(1, 0, 0, 0, 0, 0, 0, 0);
			if (ph == 3) hold_off = 600;
			add_random(190);
			drain();
		end

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/gvs_pkg.sv
rtl/core/gvs_ctrl.sv
rtl/core/gvs_datapath.sv
rtl/core/gated_velocity_smoother.sv
rtl/core/gvs_checker.sv
verif/tb_gated_velocity_smoother.sv
